@@ rtl/archive_path_hasher_assert.svh @@
// Assertion macros for the archive path hasher.
// Included by the top level; the macros expect i_clk and i_rst_n in scope.
`ifndef ARCHIVE_PATH_HASHER_ASSERT_SVH
`define ARCHIVE_PATH_HASHER_ASSERT_SVH

// Same-cycle implication, checked outside of reset.
`define APH_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside of reset.
`define APH_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/aph_pkg.sv @@
// Shared types, constants and the CRC-32 byte step for the archive path hasher.
// No dependencies; the other design files and the testbench import this package.
package aph_pkg;

    localparam int EXT_BYTES   = 4;
    localparam int EXT_LANES   = (EXT_BYTES < 4) ? EXT_BYTES : 4;
    localparam int EXT_COUNT_W = $clog2(EXT_BYTES + 1);

    localparam logic [31:0] CRC_POLY     = 32'hEDB88320;
    localparam logic [7:0]  CH_BACKSLASH = 8'h5C;
    localparam logic [7:0]  CH_DOT       = 8'h2E;

    typedef logic [31:0] t_crc;
    typedef t_crc t_crc_table [256];

    typedef struct packed {
        logic [7:0] path_byte;
        logic       is_last;
    } t_path_beat;

    typedef struct packed {
        logic [31:0] directory_hash;
        logic [31:0] stem_hash;
        logic [31:0] extension_word;
    } t_hash_result;

    // Built at elaboration: the reflected CRC of each byte value.
    function automatic t_crc_table f_build_crc_table();
        t_crc_table tbl;
        t_crc       c;
        for (int i = 0; i < 256; i++) begin
            c = t_crc'(i);
            for (int k = 0; k < 8; k++) begin
                c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
            end
            tbl[i] = c;
        end
        return tbl;
    endfunction

    localparam t_crc_table CRC_TABLE = f_build_crc_table();

    function automatic t_crc f_crc_byte(t_crc crc, logic [7:0] b);
        return (crc >> 8) ^ CRC_TABLE[crc[7:0] ^ b];
    endfunction

endpackage

@@ rtl/archive_path_hasher.sv @@
// Top level of the archive path hasher: input register, path state, result register.
// Uses aph_pkg, aph_path_state and the assertion macros in archive_path_hasher_assert.svh.
//
// The block takes one path byte per beat and accepts a beat in every cycle in which
// o_stall is low. A beat sits in the input register while the path state folds it
// into the CRCs through one table lookup per CRC; the beat flagged as last loads the
// result register, and o_valid is that register's valid flag. The
// result register is the only place a finished result waits: while it is stalled,
// ordinary bytes keep flowing, and only a further last byte waits for it to empty.
module archive_path_hasher (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  aph_pkg::t_path_beat   i_path,
    output logic                  o_valid,
    input  logic                  i_stall,
    output aph_pkg::t_hash_result o_hash
);
    import aph_pkg::*;
    `include "archive_path_hasher_assert.svh"

    logic         r_in_valid,  n_in_valid;
    t_path_beat   r_in;
    logic         r_out_valid, n_out_valid;
    t_hash_result r_out;
    t_hash_result result;
    logic         adv;
    logic         in_take;
    logic         last_held;

    // A last beat may only move on when the result register is free or being emptied.
    assign adv     = r_in_valid && (!r_in.is_last || !r_out_valid || !i_stall);
    assign o_stall = r_in_valid && !adv;
    assign in_take = i_valid && !o_stall;

    assign last_held = r_in_valid && r_in.is_last && r_out_valid && i_stall;

    aph_path_state u_state (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (adv),
        .i_beat   (r_in),
        .o_result (result)
    );

    always_comb begin
        n_in_valid = r_in_valid;
        if (!r_in_valid || adv) begin
            n_in_valid = i_valid;
        end
        n_out_valid = r_out_valid;
        if (adv && r_in.is_last) begin
            n_out_valid = 1'b1;
        end else if (!i_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in <= i_path;
        end
        if (adv && r_in.is_last) begin
            r_out <= result;
        end
    end

    assign o_valid = r_out_valid;
    assign o_hash  = r_out;

    `APH_ASSERT_NEXT(a_last_makes_result, adv && r_in.is_last, o_valid, "result lost")
    `APH_ASSERT_NOW(a_no_overwrite, last_held, o_stall, "result overwrite")
    `APH_ASSERT_NOW(a_no_input_overrun, in_take, !r_in_valid || adv, "input register overrun")

endmodule

@@ rtl/aph_path_state.sv @@
// Running path state: CRCs of the whole path, directory and segment, and the
// extension bytes. Uses aph_pkg; the state clears after the last byte of a path.
module aph_path_state (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_step,
    input  aph_pkg::t_path_beat   i_beat,
    output aph_pkg::t_hash_result o_result
);
    import aph_pkg::*;

    t_crc                   r_crc_whole,       n_crc_whole;
    t_crc                   r_crc_dir,         n_crc_dir;
    t_crc                   r_crc_seg,         n_crc_seg;
    t_crc                   r_crc_stem_dot,    n_crc_stem_dot;
    logic                   r_dot_after_slash, n_dot_after_slash;
    logic [31:0]            r_ext_packed,      n_ext_packed;
    logic [EXT_COUNT_W-1:0] r_ext_count,       n_ext_count;
    logic                   r_dot_seen,        n_dot_seen;

    logic [7:0] b;
    t_crc       crc_seg_step;

    assign b            = i_beat.path_byte;
    assign crc_seg_step = f_crc_byte(r_crc_seg, b);

    always_comb begin
        n_crc_whole       = f_crc_byte(r_crc_whole, b);
        n_crc_dir         = r_crc_dir;
        n_crc_seg         = r_crc_seg;
        n_crc_stem_dot    = r_crc_stem_dot;
        n_dot_after_slash = r_dot_after_slash;
        n_ext_packed      = r_ext_packed;
        n_ext_count       = r_ext_count;
        n_dot_seen        = r_dot_seen;

        // The first EXT_BYTES bytes after the last dot, backslashes included, fill the extension.
        if (r_dot_seen && (r_ext_count < EXT_COUNT_W'(EXT_BYTES))) begin
            for (int lane = 0; lane < EXT_LANES; lane++) begin
                if (r_ext_count == EXT_COUNT_W'(lane)) begin
                    n_ext_packed[lane*8 +: 8] = b;
                end
            end
            n_ext_count = r_ext_count + 1'b1;
        end

        if (b == CH_BACKSLASH) begin
            n_crc_dir         = r_crc_whole;
            n_crc_seg         = '0;
            n_dot_after_slash = 1'b0;
        end else if (b == CH_DOT) begin
            n_crc_stem_dot    = r_crc_seg;
            n_dot_after_slash = 1'b1;
            n_dot_seen        = 1'b1;
            n_ext_packed      = '0;
            n_ext_count       = '0;
            n_crc_seg         = crc_seg_step;
        end else begin
            n_crc_seg         = crc_seg_step;
        end
    end

    always_comb begin
        o_result.directory_hash = n_crc_dir;
        o_result.stem_hash      = n_dot_after_slash ? n_crc_stem_dot : n_crc_seg;
        o_result.extension_word = n_ext_packed;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_beat.is_last)) begin
            r_crc_whole       <= '0;
            r_crc_dir         <= '0;
            r_crc_seg         <= '0;
            r_crc_stem_dot    <= '0;
            r_dot_after_slash <= 1'b0;
            r_ext_packed      <= '0;
            r_ext_count       <= '0;
            r_dot_seen        <= 1'b0;
        end else if (i_step) begin
            r_crc_whole       <= n_crc_whole;
            r_crc_dir         <= n_crc_dir;
            r_crc_seg         <= n_crc_seg;
            r_crc_stem_dot    <= n_crc_stem_dot;
            r_dot_after_slash <= n_dot_after_slash;
            r_ext_packed      <= n_ext_packed;
            r_ext_count       <= n_ext_count;
            r_dot_seen        <= n_dot_seen;
        end
    end

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for archive_path_hasher: streams paths a byte per beat and compares
// each result with a predictor of the directory, stem and extension words kept alongside.
// Depends on aph_pkg for the beat and result types and the separator characters.
module testbench;
    import aph_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int LONG_HOLD      = 80;

    logic         i_clk   = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_valid = 1'b0;
    logic         o_stall;
    t_path_beat   i_path  = '0;
    logic         o_valid;
    logic         i_stall = 1'b0;
    t_hash_result o_hash;

    archive_path_hasher uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_path  (i_path),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_hash  (o_hash)
    );

    // Predicted path state, folded one accepted beat at a time.
    logic [31:0]  crc_all_bytes;
    logic [31:0]  crc_dir_part;
    logic [31:0]  crc_name_part;
    logic [31:0]  crc_stem_at_dot;
    logic [31:0]  ext_word;
    logic         dot_is_after_slash;
    logic         dot_found;
    int unsigned  ext_taken;

    t_hash_result hashes_pending[$];
    t_hash_result hash_expected;
    logic [7:0]   path_buf[$];

    int  mismatches     = 0;
    int  beats_in       = 0;
    int  paths_checked  = 0;
    int  stalled_cycles = 0;
    bit  tx_idle_on     = 1'b1;
    bit  rx_idle_on     = 1'b1;
    int  rx_hold_cycles = 0;

    wire path_fire = i_valid && !o_stall;
    wire hash_fire = o_valid && !i_stall;

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    function automatic logic [31:0] crc32_fold(logic [31:0] crc, logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    task automatic clear_path_state();
        crc_all_bytes      = '0;
        crc_dir_part       = '0;
        crc_name_part      = '0;
        crc_stem_at_dot    = '0;
        ext_word           = '0;
        dot_is_after_slash = 1'b0;
        dot_found          = 1'b0;
        ext_taken          = 0;
    endtask

    task automatic fold_path_beat(input t_path_beat beat);
        t_hash_result r;
        // Up to EXT_BYTES bytes after the last dot fill the extension, separators included.
        if (dot_found && ext_taken < EXT_BYTES) begin
            if (ext_taken < 4)
                ext_word |= {24'd0, beat.path_byte} << (8 * ext_taken);
            ext_taken++;
        end
        if (beat.path_byte == CH_BACKSLASH) begin
            crc_dir_part       = crc_all_bytes;
            crc_name_part      = '0;
            dot_is_after_slash = 1'b0;
        end else if (beat.path_byte == CH_DOT) begin
            crc_stem_at_dot    = crc_name_part;
            dot_is_after_slash = 1'b1;
            dot_found          = 1'b1;
            ext_word           = '0;
            ext_taken          = 0;
            crc_name_part      = crc32_fold(crc_name_part, beat.path_byte);
        end else begin
            crc_name_part = crc32_fold(crc_name_part, beat.path_byte);
        end
        crc_all_bytes = crc32_fold(crc_all_bytes, beat.path_byte);
        if (beat.is_last) begin
            r.directory_hash = crc_dir_part;
            r.stem_hash      = dot_is_after_slash ? crc_stem_at_dot : crc_name_part;
            r.extension_word = ext_word;
            hashes_pending.insert(hashes_pending.size(), r);
            clear_path_state();
        end
    endtask

    task automatic compare_word(input string name, input logic [31:0] want,
                                input logic [31:0] got);
        if (got !== want) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %08h, actual %08h", $time, name, want, got);
        end
    endtask

    initial clear_path_state();

    // Predicts on every accepted path beat and checks every accepted result.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_stall)
                stalled_cycles++;
            if (path_fire) begin
                beats_in++;
                fold_path_beat(i_path);
            end
            if (hash_fire) begin
                if (hashes_pending.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected result, expected none, actual %h", $time, o_hash);
                end else begin
                    hash_expected = hashes_pending.pop_front();
                    paths_checked++;
                    compare_word("directory_hash", hash_expected.directory_hash,
                                 o_hash.directory_hash);
                    compare_word("stem_hash", hash_expected.stem_hash, o_hash.stem_hash);
                    compare_word("extension_word", hash_expected.extension_word,
                                 o_hash.extension_word);
                end
            end
        end
    end

    initial begin : watchdog
        int idle_count;
        idle_count = 0;
        wait (i_rst_n === 1'b1);
        while (idle_count < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if (path_fire || hash_fire)
                idle_count = 0;
            else
                idle_count++;
        end
        $display("Timeout: no beat moved for %0d cycles.", WATCHDOG_LIMIT);
        $display("TEST FAILED");
        $finish;
    end

    // Result side: random stall before each result while idling is on, or one long hold when requested.
    initial begin : receiver
        int n;
        wait (i_rst_n === 1'b1);
        forever begin
            if (rx_hold_cycles > 0) begin
                n = rx_hold_cycles;
                rx_hold_cycles = 0;
            end else if (rx_idle_on) begin
                n = $urandom_range(0, 5);
            end else begin
                n = 0;
            end
            if (n > 0) begin
                i_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    task automatic send_beat(input t_path_beat beat);
        int gap;
        gap = tx_idle_on ? $urandom_range(0, 5) : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_path  <= beat;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic send_path();
        t_path_beat beat;
        for (int i = 0; i < path_buf.size(); i++) begin
            beat.path_byte = path_buf[i];
            beat.is_last   = (i == path_buf.size() - 1);
            send_beat(beat);
        end
    endtask

    task automatic add_path_byte(input logic [7:0] b);
        path_buf.insert(path_buf.size(), b);
    endtask

    task automatic send_text(input string s);
        path_buf.delete();
        for (int i = 0; i < s.len(); i++)
            add_path_byte(s[i]);
        send_path();
    endtask

    // The sender goes quiet until every predicted result has been taken.
    task automatic drain_results();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (hashes_pending.size() != 0)
            @(posedge i_clk);
    endtask

    function automatic logic [7:0] name_byte();
        if ($urandom_range(0, 9) < 3)
            return 8'($urandom_range(0, 255));
        return 8'($urandom_range(8'h61, 8'h7A));
    endfunction

    // Mostly well-formed paths (dirs, stem, dotted extensions); the rest is byte noise.
    task automatic build_random_path();
        int ndirs;
        int nlen;
        int ndots;
        int pick;
        path_buf.delete();
        if ($urandom_range(0, 9) == 0) begin
            nlen = $urandom_range(1, 16);
            repeat (nlen) begin
                pick = $urandom_range(0, 7);
                if (pick == 0)
                    add_path_byte(CH_BACKSLASH);
                else if (pick == 1)
                    add_path_byte(CH_DOT);
                else
                    add_path_byte(8'($urandom_range(0, 255)));
            end
        end else begin
            ndirs = $urandom_range(0, 3);
            repeat (ndirs) begin
                nlen = $urandom_range(1, 6);
                repeat (nlen) add_path_byte(name_byte());
                add_path_byte(CH_BACKSLASH);
            end
            nlen = $urandom_range(0, 6);
            repeat (nlen) add_path_byte(name_byte());
            ndots = $urandom_range(0, 2);
            repeat (ndots) begin
                add_path_byte(CH_DOT);
                nlen = $urandom_range(0, 6);
                repeat (nlen) add_path_byte(name_byte());
            end
            if (path_buf.size() == 0)
                add_path_byte(name_byte());
        end
    endtask

    task automatic test_directed_paths();
        send_text("\\");
        send_text(".");
        send_text("a.b\\c");          // dot before the last backslash
        send_text("x.\\y");           // extension picks up the backslash
        send_text("d\\s.extens");     // extension longer than the packed bytes
        send_text("n..");
        path_buf.delete();
        add_path_byte(8'hFF);
        add_path_byte(8'h00);
        send_path();
        drain_results();
    endtask

    task automatic test_random_paths();
        int sent;
        sent = 0;
        while (sent < 1150) begin
            // One stretch in the middle runs with no idling on either side.
            tx_idle_on = !(sent >= 400 && sent < 600);
            rx_idle_on = tx_idle_on;
            build_random_path();
            sent += path_buf.size();
            send_path();
        end
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        drain_results();
    endtask

    // Short paths with no gaps, so last bytes can arrive in consecutive cycles.
    task automatic test_back_to_back();
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        repeat (60) begin
            path_buf.delete();
            repeat ($urandom_range(1, 2)) add_path_byte(name_byte());
            send_path();
        end
        drain_results();
    endtask

    // The result side holds off while single-byte paths keep coming, filling the block.
    task automatic test_result_backpressure();
        tx_idle_on     = 1'b0;
        rx_idle_on     = 1'b0;
        rx_hold_cycles = LONG_HOLD;
        repeat (40) begin
            path_buf.delete();
            add_path_byte(name_byte());
            send_path();
        end
        drain_results();
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_paths();
        test_random_paths();
        test_back_to_back();
        test_result_backpressure();
        i_valid <= 1'b0;
        while (hashes_pending.size() != 0)
            @(posedge i_clk);
        repeat (6) @(posedge i_clk);
        $display("Checked %0d path hashes from %0d beats, including a long result hold;",
                 paths_checked, beats_in);
        $display("the input side was held back on %0d cycles.", stalled_cycles);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/aph_pkg.sv
rtl/aph_path_state.sv
rtl/archive_path_hasher.sv
tb/testbench.sv
